>>> hdl/pfx_pkg.sv
// Package holding the character codes, operator codes and error codes of the postfix evaluator.
`timescale 1ns / 1ps

package pfx_pkg;

    // Character codes taken from the input stream.
    localparam logic [7:0] CH_DIGIT_ZERO = 8'd48;
    localparam logic [7:0] CH_DIGIT_NINE = 8'd57;
    localparam logic [7:0] CH_PLUS       = 8'd43;
    localparam logic [7:0] CH_MINUS      = 8'd45;
    localparam logic [7:0] CH_STAR       = 8'd42;
    localparam logic [7:0] CH_SLASH      = 8'd47;

    // Operator held while an operation runs.
    typedef logic [1:0] op_t;
    localparam op_t OP_ADD = 2'd0;
    localparam op_t OP_SUB = 2'd1;
    localparam op_t OP_MUL = 2'd2;
    localparam op_t OP_DIV = 2'd3;

    // Error codes reported with each result.
    typedef logic [2:0] err_t;
    localparam err_t ERR_OK    = 3'd0;
    localparam err_t ERR_UNDER = 3'd1;
    localparam err_t ERR_OVER  = 3'd2;
    localparam err_t ERR_DIVZ  = 3'd3;
    localparam err_t ERR_EMPTY = 3'd4;

endpackage

>>> hdl/pfx_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module pfx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/postfix_expression_evaluator_unit.sv
// Top level of the postfix (reverse Polish) expression evaluator.
`timescale 1ns / 1ps

// The block reads a postfix expression one ASCII character per input word.
// A digit '0' to '9' pushes its value onto an operand stack held in a RAM of
// STACK_DEPTH entries, with the top entry also kept in a register. The
// operators + - * / pop the right and then the left operand and push
// (left op right); addition, subtraction and multiplication wrap at
// VALUE_WIDTH bits and division truncates towards zero. Other characters are
// ignored. On the word marked with tlast, the character is processed first,
// then one result word carries the top of the stack (sign-extended or cut to
// 32 bits) and an error code, and the stack and error are cleared. The first
// error of an expression sticks and later characters are then ignored:
// 1 underflow, 2 overflow, 3 divide by zero, 4 empty stack, with a value of 0.
// Steps: a digit or an ignored character is taken while idle; an addition or
// a subtraction passes accept, operand read from the stack RAM with the sum
// formed in the same cycle, and write back; a multiplication passes accept,
// operand read, the shift-and-add steps and write back; a division passes
// accept, operand read, left then right operand magnitude, VALUE_WIDTH
// quotient steps, quotient sign and write back. One shared adder works a
// shift-and-add multiplication or a restoring division one bit per cycle. A
// word marked last then passes the final state, which loads the result
// register. s_axis_tready is low while an operation runs; a result waiting in
// the output register does not hold up the input until the next result is due.
module postfix_expression_evaluator_unit
    import pfx_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic        s_axis_tlast,   // last
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [31:0] value, [34:32] error, [39:35] zero
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int SW = $clog2(VALUE_WIDTH);
    localparam int W  = VALUE_WIDTH;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_FETCH  = 4'd1;
    localparam logic [3:0] ST_MUL    = 4'd2;
    localparam logic [3:0] ST_NEGA   = 4'd3;
    localparam logic [3:0] ST_NEGB   = 4'd4;
    localparam logic [3:0] ST_DIV    = 4'd5;
    localparam logic [3:0] ST_NEGQ   = 4'd6;
    localparam logic [3:0] ST_COMMIT = 4'd7;
    localparam logic [3:0] ST_FINAL  = 4'd8;

    // Control registers.
    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    err_t          err_reg, err_next;
    logic          out_valid_reg, out_valid_next;

    // Working registers.
    op_t           op_reg, op_next;
    logic          last_reg, last_next;
    logic [W-1:0]  tos_reg, tos_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  res_reg, res_next;
    logic [SW-1:0] step_reg, step_next;
    logic          sa_reg, sa_next;
    logic          sb_reg, sb_next;
    logic          nq_reg, nq_next;
    logic [31:0]   out_value_reg, out_value_next;
    err_t          out_err_reg, out_err_next;

    // Stack RAM port.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [W-1:0]  ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [W-1:0]  ram_rdata;

    // Shared adder.
    logic [W:0]    add_x;
    logic [W:0]    add_y;
    logic          add_sub;
    logic [W:0]    add_sum;
    logic [W-1:0]  sum_w;

    logic          in_fire;
    logic          is_digit;
    logic          is_op;
    op_t           ch_op;
    logic [CW-1:0] count_m2;
    logic [W:0]    rem_shift;
    logic          last_step;
    logic          q_bit;
    logic [W+31:0] tos_sx;
    err_t          final_err;

    pfx_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && (state_reg == ST_IDLE);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_err_reg, out_value_reg};

    // Character decode.
    assign is_digit = (s_axis_tdata >= CH_DIGIT_ZERO) && (s_axis_tdata <= CH_DIGIT_NINE);
    assign is_op    = (s_axis_tdata == CH_PLUS) || (s_axis_tdata == CH_MINUS)
                   || (s_axis_tdata == CH_STAR) || (s_axis_tdata == CH_SLASH);

    always_comb
    begin
        priority if (s_axis_tdata == CH_PLUS)
        begin
            ch_op = OP_ADD;
        end
        else if (s_axis_tdata == CH_MINUS)
        begin
            ch_op = OP_SUB;
        end
        else if (s_axis_tdata == CH_STAR)
        begin
            ch_op = OP_MUL;
        end
        else
        begin
            ch_op = OP_DIV;
        end
    end

    // The left operand sits two below the count; the RAM is read there from IDLE on.
    assign count_m2  = count_reg - CW'(2);
    assign ram_raddr = count_m2[AW-1:0];

    // Partial remainder shifted left with the next dividend bit.
    assign rem_shift = {acc_reg, a_reg[W-1]};
    assign last_step = (step_reg == SW'(W - 1));

    // Operand selection for the shared adder.
    always_comb
    begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        unique case (state_reg)
            ST_FETCH:
            begin
                add_x   = {1'b0, ram_rdata};
                add_y   = {1'b0, tos_reg};
                add_sub = (op_reg == OP_SUB);
            end
            ST_MUL:
            begin
                add_x = {1'b0, acc_reg};
                add_y = {1'b0, a_reg};
            end
            ST_NEGA, ST_NEGQ:
            begin
                add_y   = {1'b0, a_reg};
                add_sub = 1'b1;
            end
            ST_NEGB:
            begin
                add_y   = {1'b0, b_reg};
                add_sub = 1'b1;
            end
            ST_DIV:
            begin
                add_x   = rem_shift;
                add_y   = {1'b0, b_reg};
                add_sub = 1'b1;
            end
            default:
            begin
                add_x   = '0;
                add_y   = '0;
                add_sub = 1'b0;
            end
        endcase
    end

    assign add_sum = add_x + (add_y ^ {(W + 1){add_sub}}) + {{W{1'b0}}, add_sub};
    assign sum_w   = add_sum[W-1:0];
    // In a division step a clear top bit means the trial subtraction fitted.
    assign q_bit   = ~add_sum[W];

    // Result formatting at the end of an expression.
    assign tos_sx    = {{32{tos_reg[W-1]}}, tos_reg};
    assign final_err = (err_reg != ERR_OK) ? err_reg
                     : ((count_reg == '0) ? ERR_EMPTY : ERR_OK);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        op_next        = op_reg;
        last_next      = last_reg;
        tos_next       = tos_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        acc_next       = acc_reg;
        res_next       = res_reg;
        step_next      = step_reg;
        sa_next        = sa_reg;
        sb_next        = sb_reg;
        nq_next        = nq_reg;
        out_value_next = out_value_reg;
        out_err_next   = out_err_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[AW-1:0];
        ram_wdata      = {{(W - 4){1'b0}}, 4'(s_axis_tdata - CH_DIGIT_ZERO)};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    last_next  = s_axis_tlast;
                    op_next    = ch_op;
                    state_next = s_axis_tlast ? ST_FINAL : ST_IDLE;
                    if (err_reg == ERR_OK)
                    begin
                        if (is_digit)
                        begin
                            if (count_reg >= CW'(STACK_DEPTH))
                            begin
                                err_next = ERR_OVER;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                tos_next   = ram_wdata;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        else if (is_op)
                        begin
                            if (count_reg < CW'(2))
                            begin
                                err_next = ERR_UNDER;
                            end
                            else
                            begin
                                state_next = ST_FETCH;
                            end
                        end
                    end
                end
            end

            ST_FETCH:
            begin
                // The left operand arrives from the RAM; the right one is the top register.
                a_next    = ram_rdata;
                b_next    = tos_reg;
                acc_next  = '0;
                step_next = '0;
                sa_next   = ram_rdata[W-1];
                sb_next   = tos_reg[W-1];
                nq_next   = ram_rdata[W-1] ^ tos_reg[W-1];
                unique case (op_reg)
                    OP_ADD, OP_SUB:
                    begin
                        res_next   = sum_w;
                        state_next = ST_COMMIT;
                    end
                    OP_MUL:
                    begin
                        state_next = ST_MUL;
                    end
                    OP_DIV:
                    begin
                        if (tos_reg == '0)
                        begin
                            err_next   = ERR_DIVZ;
                            state_next = last_reg ? ST_FINAL : ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_NEGA;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_MUL:
            begin
                if (b_reg[0])
                begin
                    acc_next = sum_w;
                end
                a_next    = {a_reg[W-2:0], 1'b0};
                b_next    = {1'b0, b_reg[W-1:1]};
                step_next = step_reg + SW'(1);
                if (last_step)
                begin
                    res_next   = b_reg[0] ? sum_w : acc_reg;
                    state_next = ST_COMMIT;
                end
            end

            ST_NEGA:
            begin
                if (sa_reg)
                begin
                    a_next = sum_w;
                end
                state_next = ST_NEGB;
            end

            ST_NEGB:
            begin
                if (sb_reg)
                begin
                    b_next = sum_w;
                end
                step_next  = '0;
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                acc_next  = q_bit ? sum_w : rem_shift[W-1:0];
                a_next    = {a_reg[W-2:0], q_bit};
                step_next = step_reg + SW'(1);
                if (last_step)
                begin
                    state_next = ST_NEGQ;
                end
            end

            ST_NEGQ:
            begin
                res_next   = nq_reg ? sum_w : a_reg;
                state_next = ST_COMMIT;
            end

            ST_COMMIT:
            begin
                // The result replaces the left operand and becomes the new top.
                ram_we     = 1'b1;
                ram_waddr  = count_m2[AW-1:0];
                ram_wdata  = res_reg;
                tos_next   = res_reg;
                count_next = count_reg - CW'(1);
                state_next = last_reg ? ST_FINAL : ST_IDLE;
            end

            ST_FINAL:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_err_next   = final_err;
                    out_value_next = (final_err == ERR_OK) ? tos_sx[31:0] : 32'd0;
                    count_next     = '0;
                    err_next       = ERR_OK;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            err_reg       <= ERR_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        last_reg      <= last_next;
        tos_reg       <= tos_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        acc_reg       <= acc_next;
        res_reg       <= res_next;
        step_reg      <= step_next;
        sa_reg        <= sa_next;
        sb_reg        <= sb_next;
        nq_reg        <= nq_next;
        out_value_reg <= out_value_next;
        out_err_reg   <= out_err_next;
    end

endmodule
